// ----- hw/rtl/spmd_pkg.sv -----
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared types and constants for the stereo peak meter with decay.
// ----------------------------------------------------------------------------
package spmd_pkg;

    localparam int LEVEL_FRAC_BITS_DEF = 16;
    localparam int SAMPLE_W            = 32;
    localparam int FACTOR_W            = 16;
    localparam int OUT_W               = 17;
    localparam int OUT_FRAC_BITS       = 16;
    localparam int CFG_IDX_W           = 2;

    localparam logic [FACTOR_W-1:0] BLOCK_DECAY_RST   = 16'd36045;
    localparam logic [FACTOR_W-1:0] IDLE_DECAY_RST    = 16'd45875;
    localparam logic [FACTOR_W-1:0] SILENCE_FLOOR_RST = 16'd131;

    typedef enum logic [1:0] {
        ACT_SAMPLE  = 2'd0,
        ACT_BLOCK   = 2'd1,
        ACT_IDLE    = 2'd2,
        ACT_CAPDOWN = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_DECAY   = 2'd0,
        REG_IDLE_DECAY    = 2'd1,
        REG_SILENCE_FLOOR = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic sample_en;
        logic block_en;
        logic tick_en;
        logic floor_en;
    } lane_ctrl_t;

endpackage

// ----- hw/rtl/spmd_lane.sv -----
// ----------------------------------------------------------------------------
// spmd_lane
// One meter channel: sample to level conversion, running peak and level decay.
// ----------------------------------------------------------------------------
module spmd_lane #(
    parameter int LEVEL_FRAC_BITS = spmd_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  spmd_pkg::lane_ctrl_t          ctrl,
    input  logic [spmd_pkg::SAMPLE_W-1:0] sample,
    input  logic [spmd_pkg::FACTOR_W-1:0] block_decay,
    input  logic [spmd_pkg::FACTOR_W-1:0] idle_decay,
    input  logic [spmd_pkg::FACTOR_W-1:0] silence_floor,
    output logic [LEVEL_FRAC_BITS:0]      level_out
);
    import spmd_pkg::*;

    localparam int LW      = LEVEL_FRAC_BITS + 1;
    localparam int SH_BASE = 150 - LEVEL_FRAC_BITS;
    localparam int MANT_W  = 24;
    localparam int PROD_W  = LW + FACTOR_W;
    localparam int CMP_W   = (LW > FACTOR_W) ? LW : FACTOR_W;
    localparam logic [LW-1:0] LEVEL_ONE = LW'(1) << LEVEL_FRAC_BITS;

    logic [LW-1:0]       peak_reg, peak_next;
    logic [LW-1:0]       level_reg, level_next;
    logic [30:0]         mag;
    logic [7:0]          expo;
    logic [MANT_W-1:0]   mant;
    logic [8:0]          shamt;
    logic [LW-1:0]       conv;
    logic                finite;
    logic [FACTOR_W-1:0] factor;
    logic [PROD_W-1:0]   prod;
    logic [LW-1:0]       decayed;

    // binary32 magnitude to clipped fixed point, truncating
    always_comb begin
        mag    = sample[30:0];
        finite = (sample[30:23] != 8'hFF);
        if (mag[30:23] == 8'd0) begin
            expo = 8'd1;
            mant = {1'b0, mag[22:0]};
        end else begin
            expo = mag[30:23];
            mant = {1'b1, mag[22:0]};
        end
        shamt = 9'(SH_BASE) - {1'b0, expo};
        if (mag >= 31'h3F800000) begin
            conv = LEVEL_ONE;
        end else if (shamt == 9'd0) begin
            conv = LEVEL_ONE;
        end else if (shamt >= 9'(MANT_W)) begin
            conv = '0;
        end else begin
            conv = LW'(mant >> shamt[4:0]);
        end
    end

    assign factor  = ctrl.block_en ? block_decay : idle_decay;
    assign prod    = PROD_W'(level_reg) * PROD_W'(factor);
    assign decayed = prod[PROD_W-1:FACTOR_W];

    always_comb begin
        peak_next  = peak_reg;
        level_next = level_reg;
        if (ctrl.sample_en) begin
            if (finite && (conv > peak_reg)) begin
                peak_next = conv;
            end
        end
        if (ctrl.block_en) begin
            level_next = (peak_reg > decayed) ? peak_reg : decayed;
            peak_next  = '0;
        end
        if (ctrl.tick_en) begin
            level_next = decayed;
            if (ctrl.floor_en && (CMP_W'(decayed) < CMP_W'(silence_floor))) begin
                level_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg  <= '0;
            level_reg <= '0;
        end else begin
            peak_reg  <= peak_next;
            level_reg <= level_next;
        end
    end

    assign level_out = level_next;

    a_block_clears_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.block_en |=> (peak_reg == '0))
        else $error("peak not cleared after block end");
    a_level_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (level_reg <= LEVEL_ONE) && (peak_reg <= LEVEL_ONE))
        else $error("level or peak above full scale");
    a_tick_keeps_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.tick_en |=> (peak_reg == $past(peak_reg)))
        else $error("peak changed on a tick");

endmodule

// ----- hw/rtl/spmd_out.sv -----
// ----------------------------------------------------------------------------
// spmd_out
// Merges both lane levels into one result, scales to Q1.16 and buffers it.
// ----------------------------------------------------------------------------
module spmd_out #(
    parameter int LEVEL_FRAC_BITS = spmd_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [LEVEL_FRAC_BITS:0]   left_in,
    input  logic [LEVEL_FRAC_BITS:0]   right_in,
    output logic                       room,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [spmd_pkg::OUT_W-1:0] m_left_level,
    output logic [spmd_pkg::OUT_W-1:0] m_right_level
);
    import spmd_pkg::*;

    localparam int DOWN = (LEVEL_FRAC_BITS >= OUT_FRAC_BITS) ?
                          LEVEL_FRAC_BITS - OUT_FRAC_BITS : 0;
    localparam int UP   = (LEVEL_FRAC_BITS < OUT_FRAC_BITS) ?
                          OUT_FRAC_BITS - LEVEL_FRAC_BITS : 0;

    logic [OUT_W-1:0] left_cvt, right_cvt;
    logic             out_valid_reg, skid_valid_reg;
    logic [OUT_W-1:0] out_left_reg, out_right_reg;
    logic [OUT_W-1:0] skid_left_reg, skid_right_reg;

    assign left_cvt  = OUT_W'(left_in >> DOWN) << UP;
    assign right_cvt = OUT_W'(right_in >> DOWN) << UP;

    assign room = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_left_reg  <= skid_left_reg;
                out_right_reg <= skid_right_reg;
            end else if (push) begin
                out_left_reg  <= left_cvt;
                out_right_reg <= right_cvt;
            end
        end else if (push) begin
            skid_left_reg  <= left_cvt;
            skid_right_reg <= right_cvt;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_left_level  = out_left_reg;
    assign m_right_level = out_right_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full while output slot empty");
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("result pushed into full buffer");
    a_skid_moves_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=>
            (m_left_level == $past(skid_left_reg)) &&
            (m_right_level == $past(skid_right_reg)))
        else $error("skid entry lost on transfer");

endmodule

// ----- hw/rtl/stereo_peak_meter_decay.sv -----
// ----------------------------------------------------------------------------
// stereo_peak_meter_decay
// Stereo peak meter: per-frame peak capture, block-end and tick level decay.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle while s_ready is high. Each channel
// lane converts, compares and multiplies combinationally, so the level
// state is ready for the next item. Results go through a two-entry output
// buffer; s_ready falls only while both entries hold results that have not
// been transferred, and sample frames, which give no result, still need a
// free entry to be taken.
module stereo_peak_meter_decay #(
    parameter int LEVEL_FRAC_BITS = spmd_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [spmd_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [spmd_pkg::FACTOR_W-1:0]  cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_action,
    input  logic [spmd_pkg::SAMPLE_W-1:0]  s_left_sample,
    input  logic [spmd_pkg::SAMPLE_W-1:0]  s_right_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [spmd_pkg::OUT_W-1:0]     m_left_level,
    output logic [spmd_pkg::OUT_W-1:0]     m_right_level
);
    import spmd_pkg::*;

    logic [FACTOR_W-1:0]      block_decay_reg, idle_decay_reg, silence_floor_reg;
    logic                     frame_seen_reg, frame_seen_next;
    logic                     accept, push;
    action_t                  action;
    lane_ctrl_t               ctrl;
    logic [LEVEL_FRAC_BITS:0] left_level, right_level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_decay_reg   <= BLOCK_DECAY_RST;
            idle_decay_reg    <= IDLE_DECAY_RST;
            silence_floor_reg <= SILENCE_FLOOR_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_idx))
                REG_BLOCK_DECAY:   block_decay_reg   <= cfg_wdata;
                REG_IDLE_DECAY:    idle_decay_reg    <= cfg_wdata;
                REG_SILENCE_FLOOR: silence_floor_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign action = action_t'(s_action);
    assign accept = s_valid && s_ready;
    assign push   = accept && (action != ACT_SAMPLE);

    always_comb begin
        ctrl            = '0;
        frame_seen_next = frame_seen_reg;
        if (accept) begin
            unique case (action)
                ACT_SAMPLE: begin
                    ctrl.sample_en  = 1'b1;
                    frame_seen_next = 1'b1;
                end
                ACT_BLOCK: begin
                    ctrl.block_en   = frame_seen_reg;
                    frame_seen_next = 1'b0;
                end
                ACT_IDLE: begin
                    ctrl.tick_en  = 1'b1;
                    ctrl.floor_en = 1'b1;
                end
                ACT_CAPDOWN: begin
                    ctrl.tick_en = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_seen_reg <= 1'b0;
        end else begin
            frame_seen_reg <= frame_seen_next;
        end
    end

    spmd_lane #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_lane_left (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .sample        (s_left_sample),
        .block_decay   (block_decay_reg),
        .idle_decay    (idle_decay_reg),
        .silence_floor (silence_floor_reg),
        .level_out     (left_level)
    );

    spmd_lane #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_lane_right (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .sample        (s_right_sample),
        .block_decay   (block_decay_reg),
        .idle_decay    (idle_decay_reg),
        .silence_floor (silence_floor_reg),
        .level_out     (right_level)
    );

    spmd_out #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .left_in       (left_level),
        .right_in      (right_level),
        .room          (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_level  (m_left_level),
        .m_right_level (m_right_level)
    );

    a_block_clears_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (action == ACT_BLOCK)) |=> !frame_seen_reg)
        else $error("frame mark kept after block end");
    a_sample_sets_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (action == ACT_SAMPLE)) |=> frame_seen_reg)
        else $error("frame mark not set by sample transfer");
    a_single_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctrl.sample_en, ctrl.block_en, ctrl.tick_en}))
        else $error("more than one lane operation in a cycle");

endmodule
